// File: rtl/acd_pkg.sv
package acd_pkg;

  // Round key store: one 128-bit round key per entry, rounds 0 to 10
  localparam int unsigned RK_DEPTH = 11;
  localparam int unsigned RK_AW    = $clog2(RK_DEPTH);
  localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(RK_DEPTH - 1);

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_HI = 2'd0;
  localparam logic [1:0] REG_KEY_LO = 2'd1;
  localparam logic [1:0] REG_IV_HI  = 2'd2;
  localparam logic [1:0] REG_IV_LO  = 2'd3;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1b;

  // Round key write towards the key store
  typedef struct packed {
    logic             en;
    logic [RK_AW-1:0] addr;
    logic [127:0]     data;
  } rk_wr_t;

  // Key expansion status
  typedef struct packed {
    logic busy;
    logic last;
  } kexp_stat_t;

  // Round unit mode
  typedef struct packed {
    logic add_only;
    logic mix;
  } rnd_mode_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

  // Forward S-box on each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // Inverse mix of one column; row 0 in the top byte
  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    for (int r = 0; r < 4; r++) begin
      a[r]   = w[31-8*r -: 8];
      x2[r]  = xt(a[r]);
      x4[r]  = xt(x2[r]);
      x8[r]  = xt(x4[r]);
      m9[r]  = x8[r] ^ a[r];
      m11[r] = x8[r] ^ x2[r] ^ a[r];
      m13[r] = x8[r] ^ x4[r] ^ a[r];
      m14[r] = x8[r] ^ x4[r] ^ x2[r];
    end
    return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
            m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
            m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
            m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
  endfunction

endpackage

// File: rtl/acd_ram.sv
module acd_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/acd_key_exp.sv
module acd_key_exp
  import acd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] key_i,
  output rk_wr_t       wr_o,
  output kexp_stat_t   stat_o
);

  logic [127:0]     rk_q;
  logic [7:0]       rcon_q;
  logic [RK_AW-1:0] cnt_q;
  logic             busy_q;

  logic [31:0]  w0, w1, w2, w3, t, n0, n1, n2, n3;
  logic [127:0] rk_next;

  // Next round key from the current one: one S-box word per round
  always_comb begin
    w0 = rk_q[127:96];
    w1 = rk_q[95:64];
    w2 = rk_q[63:32];
    w3 = rk_q[31:0];
    t  = sub_word({w3[23:0], w3[31:24]}) ^ {rcon_q, 24'h000000};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    rk_next = {n0, n1, n2, n3};
  end

  // Control: while busy, one round key written per cycle, rounds 0 to 10
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == LAST_ROUND) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + RK_AW'(1);
      end
    end
  end

  // Key words and round constant
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rk_q   <= key_i;
      rcon_q <= RCON_FIRST;
    end else if (busy_q) begin
      rk_q   <= rk_next;
      rcon_q <= xt(rcon_q);
    end
  end

  assign wr_o.en     = busy_q;
  assign wr_o.addr   = cnt_q;
  assign wr_o.data   = rk_q;
  assign stat_o.busy = busy_q;
  assign stat_o.last = busy_q && (cnt_q == LAST_ROUND);

endmodule

// File: rtl/acd_round.sv
module acd_round
  import acd_pkg::*;
(
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  input  rnd_mode_t    mode_i,
  output logic [127:0] state_o
);

  logic [127:0] shsub;
  logic [127:0] added;
  logic [127:0] mixed;

  // Inverse shift rows and inverse S-box; byte k is row k%4, column k/4
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shsub[127-8*(4*c+r) -: 8] = INV_SBOX[state_i[127-8*(4*((c-r)&3)+r) -: 8]];
      end
    end
  end

  // Round key add, then inverse mix columns
  always_comb begin
    added = (mode_i.add_only ? state_i : shsub) ^ key_i;
    for (int c = 0; c < 4; c++) begin
      mixed[127-32*c -: 32] = inv_mix_col(added[127-32*c -: 32]);
    end
  end

  assign state_o = (mode_i.mix && !mode_i.add_only) ? mixed : added;

endmodule

// File: rtl/aes128_cbc_decrypt.sv
// AES-128 CBC decryption, one shared inverse round unit.
// A chained block goes from the input beat straight to the rounds; a first block
// first expands the key (ST_KEXP) and reads round key 10 (ST_LOAD).
// A new block is accepted only in ST_IDLE, once the result of the last one is emitted.
// Reset clears control, configuration and the chaining value; the round key
// store is not cleared and holds valid keys only after the first first block.
module aes128_cbc_decrypt
  import acd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] cipher_hi_i,
  input  logic [63:0] cipher_lo_i,
  input  logic        first_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] plain_hi_o,
  output logic [63:0] plain_lo_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEXP  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [63:0]      key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic [127:0]     cin_q, st_q, chain_q, out_q;
  logic [RK_AW-1:0] rnd_q;
  logic             out_valid_q;

  logic             in_acc, out_fire, out_free, emit;
  logic [127:0]     emit_src;
  logic [RK_AW-1:0] raddr;
  logic [127:0]     rk_rdata, rnd_state;
  rk_wr_t           rk_wr;
  kexp_stat_t       kexp_stat;
  rnd_mode_t        rnd_mode;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && out_stall_i == 1'b0;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      iv_hi_q  <= '0;
      iv_lo_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_HI: key_hi_q <= cfg_data_i;
        REG_KEY_LO: key_lo_q <= cfg_data_i;
        REG_IV_HI:  iv_hi_q  <= cfg_data_i;
        REG_IV_LO:  iv_lo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  acd_key_exp u_key_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_acc && first_block_i),
    .key_i  ({key_hi_q, key_lo_q}),
    .wr_o   (rk_wr),
    .stat_o (kexp_stat)
  );

  // Round keys 10 down to 0 are read ahead of use, through the registered read port of the key store
  assign raddr = (state_q == ST_ROUND && rnd_q != '0) ? rnd_q - RK_AW'(1) : LAST_ROUND;

  acd_ram #(
    .WIDTH(128),
    .DEPTH(RK_DEPTH)
  ) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (rk_wr.en),
    .waddr_i(rk_wr.addr),
    .wdata_i(rk_wr.data),
    .raddr_i(raddr),
    .rdata_o(rk_rdata)
  );

  assign rnd_mode.add_only = (rnd_q == LAST_ROUND);
  assign rnd_mode.mix      = (rnd_q != '0);

  acd_round u_round (
    .state_i(rnd_mode.add_only ? cin_q : st_q),
    .key_i  (rk_rdata),
    .mode_i (rnd_mode),
    .state_o(rnd_state)
  );

  // Result goes out at the last round, or later from ST_OUT if the slot is full
  always_comb begin
    emit     = 1'b0;
    emit_src = st_q;
    if (state_q == ST_ROUND && rnd_q == '0 && out_free) begin
      emit     = 1'b1;
      emit_src = rnd_state;
    end else if (state_q == ST_OUT && out_free) begin
      emit = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = first_block_i ? ST_KEXP : ST_ROUND;
        end
      end
      ST_KEXP: begin
        if (kexp_stat.last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == '0) begin
          state_d = emit ? ST_IDLE : ST_OUT;
        end
      end
      ST_OUT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_d == ST_ROUND && state_q != ST_ROUND) begin
        rnd_q <= LAST_ROUND;
      end else if (state_q == ST_ROUND && rnd_q != '0) begin
        rnd_q <= rnd_q - RK_AW'(1);
      end
      if (in_acc && first_block_i) begin
        chain_q <= {iv_hi_q, iv_lo_q};
      end else if (emit) begin
        chain_q <= cin_q;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cin_q <= {cipher_hi_i, cipher_lo_i};
    end
    if (state_q == ST_ROUND) begin
      st_q <= rnd_state;
    end
    if (emit) begin
      out_q <= emit_src ^ chain_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign plain_hi_o  = out_q[127:64];
  assign plain_lo_o  = out_q[63:0];

  // Checks on the sequencer
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE)
    else $error("beat accepted while busy");

  a_first_kexp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && first_block_i |=> state_q == ST_KEXP && kexp_stat.busy)
    else $error("first block did not start key expansion");

  a_kexp_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kexp_stat.busy |-> state_q == ST_KEXP)
    else $error("key expansion running outside its state");

  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> rnd_q <= LAST_ROUND)
    else $error("round counter out of range");

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND && rnd_q == '0 |=> (state_q == ST_IDLE || state_q == ST_OUT)
      && out_valid_q)
    else $error("last round did not hand over a result");

endmodule
